/* src/kmp_pkg.sv */
// Shared codes, types and controller/datapath bundles for the KMP matcher.
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 16;

    typedef logic [2:0]       status_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam status_t ST_NONE     = 3'd0;
    localparam status_t ST_MATCH    = 3'd1;
    localparam status_t ST_NOMATCH  = 3'd2;
    localparam status_t ST_NOPAT    = 3'd3;
    localparam status_t ST_OVERFLOW = 3'd4;

    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the incoming word, issue the first link read
        logic step;     // one comparison / link step of the walk
        logic commit;   // update state and load the result register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_start;  // incoming word needs a walk from a nonzero prefix
        logic hit;         // stored byte at current prefix equals the word's byte
        logic link_zero;   // failure link read back is zero
        logic out_free;    // result register can take a new result
    } dp_stat_t;

endpackage

/* src/kmp_req_if.sv */
// Request channel: pattern and text words with valid/ready handshake.
`timescale 1ns / 1ps

interface kmp_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic                         first_of_run;
    logic [kmp_pkg::BYTE_W-1:0]   data_byte;
    logic                         last_of_text;

    modport source (output valid, output req_type, output first_of_run,
                    output data_byte, output last_of_text, input ready);
    modport sink   (input valid, input req_type, input first_of_run,
                    input data_byte, input last_of_text, output ready);
endinterface

/* src/kmp_rsp_if.sv */
// Response channel: match status and position with valid/ready handshake.
`timescale 1ns / 1ps

interface kmp_rsp_if;
    logic              valid;
    logic              ready;
    kmp_pkg::status_t  status;
    kmp_pkg::pos_t     match_position;

    modport source (output valid, output status, output match_position, input ready);
    modport sink   (input valid, input status, input match_position, output ready);
endinterface

/* src/kmp_stream_matcher.sv */
// Top level: KMP first-occurrence matcher, one result word per request word.
// Each word is accepted, then walks the failure links until its comparison settles (or goes
// straight to the result if no walk is needed); each link step is a registered memory read.
// Results sit in an output register; a word is taken only when the previous one is done.
// rst_n (async, active low) clears lengths, prefixes, text index, found flag and valids.
// The pattern/link memory keeps its contents; it is only read where written since a clear.
`timescale 1ns / 1ps

module kmp_stream_matcher #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_TEXT    = 65535
) (
    input logic       clk,
    input logic       rst_n,
    kmp_req_if.sink   req,
    kmp_rsp_if.source rsp
);

    kmp_pkg::ctrl_cmd_t cmd;
    kmp_pkg::dp_stat_t  stat;

    kmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kmp_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_req_type  (req.req_type),
        .in_first     (req.first_of_run),
        .in_byte      (req.data_byte),
        .in_last      (req.last_of_text),
        .out_valid    (rsp.valid),
        .out_status   (rsp.status),
        .out_position (rsp.match_position),
        .out_ready    (rsp.ready)
    );

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result loaded while output register still occupied");

    a_accept_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.commit && !cmd.step)
        else $error("accept overlaps walk or commit");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !req.ready)
        else $error("ready returned before the accepted word finished");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("committed result not presented");

endmodule

/* src/kmp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/kmp_datapath.sv */
// Datapath: pattern/link memory, prefix and text counters, link walk, result register.
`timescale 1ns / 1ps

module kmp_datapath #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_TEXT    = 65535
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kmp_pkg::ctrl_cmd_t          cmd,
    output kmp_pkg::dp_stat_t           stat,
    input  logic                        in_req_type,
    input  logic                        in_first,
    input  logic [kmp_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        in_last,
    output logic                        out_valid,
    output kmp_pkg::status_t            out_status,
    output kmp_pkg::pos_t               out_position,
    input  logic                        out_ready
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int TW = $clog2(MAX_TEXT + 1);
    localparam int CW = (TW > LW) ? TW : LW;
    localparam int DW = kmp_pkg::BYTE_W + LW;

    // state
    logic [LW-1:0] len_reg, bp_reg, mp_reg;
    logic [TW-1:0] ti_reg;
    logic          found_reg;
    logic          out_valid_reg;

    // latched word and walk prefix
    logic                       req_reg, first_reg, last_reg;
    logic [kmp_pkg::BYTE_W-1:0] byte_reg;
    logic [LW-1:0]              k_reg;
    kmp_pkg::status_t           status_reg;
    kmp_pkg::pos_t              pos_reg;

    // memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;
    logic [kmp_pkg::BYTE_W-1:0] rd_byte;
    logic [LW-1:0] rd_link;

    // incoming-word decode
    logic          in_full, in_walk;
    logic [LW-1:0] in_mp_eff, k_text, k_init;

    // commit-time values
    logic          full_r, found_eff;
    logic [LW-1:0] len_eff, bp_eff, k_fin;
    logic [TW-1:0] ti_eff, ti_new;
    logic [CW-1:0] ti_c, m_c, pos_c;

    kmp_ram #(.WIDTH(DW), .DEPTH(MAX_PATTERN)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_byte = ram_rdata[DW-1:LW];
    assign rd_link = ram_rdata[LW-1:0];

    always_comb
    begin
        in_full   = !in_first && (len_reg == LW'(MAX_PATTERN));
        in_mp_eff = in_first ? LW'(1) : mp_reg;
        k_text    = (in_mp_eff > len_reg) ? len_reg : in_mp_eff;
        if (in_req_type == kmp_pkg::REQ_PATTERN)
        begin
            in_walk = !in_full;
            k_init  = in_first ? '0 : bp_reg;
        end
        else
        begin
            in_walk = (len_reg != '0) && !(!in_first && found_reg);
            k_init  = k_text;
        end
    end

    assign stat.walk_start = in_walk && (k_init != '0);
    assign stat.hit        = (rd_byte == byte_reg);
    assign stat.link_zero  = (rd_link == '0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // during a step the next address comes straight from the link read back
    assign ram_raddr = cmd.step ? AW'(rd_link - LW'(1)) : AW'(k_init - LW'(1));

    always_comb
    begin
        full_r    = !first_reg && (len_reg == LW'(MAX_PATTERN));
        len_eff   = first_reg ? '0 : len_reg;
        bp_eff    = first_reg ? '0 : bp_reg;
        found_eff = !first_reg && found_reg;
        ti_eff    = first_reg ? '0 : ti_reg;
        ti_new    = (ti_eff < TW'(MAX_TEXT)) ? ti_eff + TW'(1) : ti_eff;
        k_fin     = cmd.step ? (stat.hit ? k_reg : '0) : k_reg;
        ti_c      = CW'(ti_new);
        m_c       = CW'(len_reg);
        pos_c     = (ti_c >= m_c) ? ti_c - m_c + CW'(1) : CW'(1);
        ram_we    = cmd.commit && (req_reg == kmp_pkg::REQ_PATTERN) && !full_r;
        ram_waddr = AW'(len_eff);
        ram_wdata = {byte_reg, bp_eff};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            bp_reg        <= '0;
            mp_reg        <= LW'(1);
            ti_reg        <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (req_reg == kmp_pkg::REQ_PATTERN)
                begin
                    if (!full_r)
                    begin
                        len_reg   <= len_eff + LW'(1);
                        bp_reg    <= k_fin + LW'(1);
                        mp_reg    <= LW'(1);
                        ti_reg    <= '0;
                        found_reg <= 1'b0;
                    end
                end
                else if (len_reg == '0 || found_eff)
                begin
                    if (first_reg)
                    begin
                        mp_reg    <= LW'(1);
                        ti_reg    <= '0;
                        found_reg <= 1'b0;
                    end
                end
                else
                begin
                    ti_reg <= ti_new;
                    if (k_fin == len_reg)
                    begin
                        found_reg <= 1'b1;
                        mp_reg    <= LW'(1);
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        mp_reg    <= k_fin + LW'(1);
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg   <= in_req_type;
            first_reg <= in_first;
            byte_reg  <= in_byte;
            last_reg  <= in_last;
            k_reg     <= k_init;
        end
        else if (cmd.step)
        begin
            k_reg <= stat.hit ? k_reg : rd_link;
        end

        if (cmd.commit)
        begin
            pos_reg <= '0;
            if (req_reg == kmp_pkg::REQ_PATTERN)
            begin
                status_reg <= full_r ? kmp_pkg::ST_OVERFLOW : kmp_pkg::ST_NONE;
            end
            else if (len_reg == '0)
            begin
                status_reg <= kmp_pkg::ST_NOPAT;
            end
            else if (found_eff)
            begin
                status_reg <= kmp_pkg::ST_NONE;
            end
            else if (k_fin == len_reg)
            begin
                status_reg <= kmp_pkg::ST_MATCH;
                pos_reg    <= kmp_pkg::pos_t'(pos_c);
            end
            else
            begin
                status_reg <= last_reg ? kmp_pkg::ST_NOMATCH : kmp_pkg::ST_NONE;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = status_reg;
    assign out_position = pos_reg;

endmodule

/* src/kmp_ctrl.sv */
// Controller: accept, link-walk and result-hold sequencing.
`timescale 1ns / 1ps

module kmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kmp_pkg::dp_stat_t  stat,
    output kmp_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       walk_done;

    assign in_ready  = (state_reg == S_IDLE);
    assign walk_done = stat.hit || stat.link_zero;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.walk_start ? S_CMP : S_FIN;
                end
            end
            S_CMP:
            begin
                cmd.step = 1'b1;
                if (walk_done)
                begin
                    if (stat.out_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sim/kmp_stream_matcher_tb.sv */
// Self-checking testbench for kmp_stream_matcher: directed table and random sequences.
`timescale 1ns / 1ps

module kmp_stream_matcher_tb;

    localparam int CLK_HALF       = 6;
    localparam int PAT_CAP        = 64;
    localparam int TEXT_CAP       = 65535;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 325;
    localparam int OVF_KIND       = 10;

    typedef struct packed {
        kmp_pkg::status_t st;
        kmp_pkg::pos_t    pos;
    } rsp_word_t;

    typedef struct packed {
        logic                       rq;
        logic                       fst;
        logic [kmp_pkg::BYTE_W-1:0] c;
        logic                       lst;
        logic                       typed;
        kmp_pkg::status_t           st;
        kmp_pkg::pos_t              pos;
    } stim_row_t;

    localparam int DIR_ROWS = 21;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{kmp_pkg::REQ_TEXT,    1'b1, 8'h00, 1'b0, 1'b1, kmp_pkg::ST_NOPAT,   16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'hFF, 1'b1, 1'b1, kmp_pkg::ST_NOPAT,   16'd0},
        '{kmp_pkg::REQ_PATTERN, 1'b1, 8'h00, 1'b0, 1'b1, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'hFF, 1'b1, 1'b1, kmp_pkg::ST_NOMATCH, 16'd0},
        // stream is not closed by last: next word still counts
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'h00, 1'b0, 1'b1, kmp_pkg::ST_MATCH,   16'd2},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'h00, 1'b1, 1'b1, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b1, 8'h00, 1'b1, 1'b1, kmp_pkg::ST_MATCH,   16'd1},
        '{kmp_pkg::REQ_PATTERN, 1'b1, 8'hFF, 1'b0, 1'b1, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_PATTERN, 1'b0, 8'hFF, 1'b1, 1'b1, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_PATTERN, 1'b0, 8'hA5, 1'b0, 1'b1, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b1, 8'hFF, 1'b0, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'hFF, 1'b0, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'hFF, 1'b0, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'hA5, 1'b1, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'hA5, 1'b1, 1'b1, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_PATTERN, 1'b0, 8'h5A, 1'b0, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'hFF, 1'b0, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b1, 8'h5A, 1'b1, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_PATTERN, 1'b1, 8'h5A, 1'b0, 1'b1, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b0, 8'h5A, 1'b1, 1'b0, kmp_pkg::ST_NONE,    16'd0},
        '{kmp_pkg::REQ_TEXT,    1'b1, 8'h00, 1'b1, 1'b1, kmp_pkg::ST_NOMATCH, 16'd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kmp_req_if req_ch ();
    kmp_rsp_if rsp_ch ();

    kmp_stream_matcher dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #CLK_HALF clk = ~clk;

    // predictor state
    logic [kmp_pkg::BYTE_W-1:0] pat_bytes [1:PAT_CAP];
    logic [6:0]                 pat_links [1:PAT_CAP+1];
    logic [6:0]                 pat_len    = '0;
    logic [6:0]                 link_pfx   = '0;
    logic [6:0]                 cmp_pfx    = 7'd1;
    logic [15:0]                txt_count  = '0;
    logic                       seen_match = 1'b0;

    rsp_word_t awaited_results [$];

    // generator state
    logic [kmp_pkg::BYTE_W-1:0] alph [4] = '{default: '0};
    int                         alph_n = 1;
    logic [kmp_pkg::BYTE_W-1:0] plan_pat [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_reqs     = 0;
    int hold_served   = 0;
    int sent_words    = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    function automatic int follow_links(input int start,
                                        input logic [kmp_pkg::BYTE_W-1:0] c);
        int k;
        k = start;
        while (k > 0 && k <= PAT_CAP && pat_bytes[k] != c)
            k = int'(pat_links[k]);
        if (k > PAT_CAP)
            k = 0;
        return k;
    endfunction

    function automatic void clear_match();
        cmp_pfx    = 7'd1;
        txt_count  = '0;
        seen_match = 1'b0;
    endfunction

    function automatic void kmp_next_result(input logic rq, input logic fst,
                                            input logic [kmp_pkg::BYTE_W-1:0] c,
                                            input logic lst,
                                            output rsp_word_t res);
        int nxt;
        int j;
        int m;
        res.st  = kmp_pkg::ST_NONE;
        res.pos = '0;
        if (rq == kmp_pkg::REQ_PATTERN)
        begin
            if (fst)
            begin
                pat_len  = '0;
                link_pfx = '0;
            end
            if (int'(pat_len) >= PAT_CAP)
                res.st = kmp_pkg::ST_OVERFLOW;
            else
            begin
                nxt = int'(pat_len) + 1;
                pat_bytes[nxt] = c;
                pat_links[nxt] = link_pfx;
                link_pfx = 7'(follow_links(int'(link_pfx), c) + 1);
                pat_len  = 7'(nxt);
                clear_match();
            end
        end
        else
        begin
            if (fst)
                clear_match();
            m = int'(pat_len);
            if (m == 0)
                res.st = kmp_pkg::ST_NOPAT;
            else if (!seen_match)
            begin
                if (int'(txt_count) < TEXT_CAP)
                    txt_count = txt_count + 16'd1;
                j = (int'(cmp_pfx) > m) ? m : int'(cmp_pfx);
                j = follow_links(j, c);
                if (j == m)
                begin
                    seen_match = 1'b1;
                    res.st     = kmp_pkg::ST_MATCH;
                    // saturated index can sit below m
                    res.pos    = (int'(txt_count) >= m)
                                 ? kmp_pkg::pos_t'(int'(txt_count) - m + 1)
                                 : kmp_pkg::pos_t'(1);
                    cmp_pfx    = 7'd1;
                end
                else
                begin
                    cmp_pfx = 7'(j + 1);
                    if (lst)
                        res.st = kmp_pkg::ST_NOMATCH;
                end
            end
        end
    endfunction

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic send_word(input logic rq, input logic fst,
                             input logic [kmp_pkg::BYTE_W-1:0] c,
                             input logic lst, input logic typed = 1'b0,
                             input kmp_pkg::status_t t_st = kmp_pkg::ST_NONE,
                             input kmp_pkg::pos_t t_pos = '0);
        int        gap;
        rsp_word_t exp_w;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= rq;
        req_ch.first_of_run <= fst;
        req_ch.data_byte    <= c;
        req_ch.last_of_text <= lst;
        do
            @(posedge clk);
        while (!req_ch.ready);
        kmp_next_result(rq, fst, c, lst, exp_w);
        if (typed)
        begin
            exp_w.st  = t_st;
            exp_w.pos = t_pos;
        end
        awaited_results.push_back(exp_w);
        sent_words++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic load_pattern(input int len, input logic fresh);
        logic [kmp_pkg::BYTE_W-1:0] c;
        if (fresh)
            plan_pat.delete();
        for (int i = 0; i < len; i++)
        begin
            c = alph[$urandom_range(alph_n - 1)];
            if (plan_pat.size() < PAT_CAP)
                plan_pat.push_back(c);
            send_word(kmp_pkg::REQ_PATTERN, fresh && i == 0, c, 1'($urandom_range(1)));
        end
    endtask

    task automatic text_run(input int len, input logic fresh, input logic mark_last);
        logic [kmp_pkg::BYTE_W-1:0] txt [$];
        while (txt.size() < len)
        begin
            if (plan_pat.size() != 0 && $urandom_range(7) == 0)
            begin
                foreach (plan_pat[k])
                    txt.push_back(plan_pat[k]);
                // near miss on the final byte
                if ($urandom_range(2) == 0)
                    txt[txt.size() - 1] = alph[$urandom_range(alph_n - 1)];
            end
            else if ($urandom_range(15) == 0)
                txt.push_back(8'($urandom_range(255)));
            else
                txt.push_back(alph[$urandom_range(alph_n - 1)]);
        end
        foreach (txt[k])
            send_word(kmp_pkg::REQ_TEXT, fresh && k == 0, txt[k],
                      mark_last && k == txt.size() - 1);
    endtask

    task automatic run_sequence(input int kind);
        int plen;
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 6))
                send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        else
        begin
            if (kind < 14 || plan_pat.size() == 0 || $urandom_range(2) != 0)
            begin
                alph_n = int'($urandom_range(1, 4));
                for (int a = 0; a < alph_n; a++)
                    alph[a] = 8'($urandom_range(255));
                if (kind < 14)
                begin
                    // fill to capacity, then push past it
                    load_pattern(PAT_CAP, 1'b1);
                    load_pattern(int'($urandom_range(1, 3)), 1'b0);
                end
                else
                begin
                    plen = int'($urandom_range(99));
                    if (plen < 70)
                        plen = int'($urandom_range(1, 6));
                    else if (plen < 92)
                        plen = int'($urandom_range(7, 20));
                    else
                        plen = int'($urandom_range(21, PAT_CAP));
                    // now and then extend the current pattern instead of clearing it
                    load_pattern(plen, $urandom_range(7) != 0);
                end
            end
            repeat ($urandom_range(1, 3))
                text_run(int'($urandom_range(1, 24 + plan_pat.size())),
                         $urandom_range(4) != 0, $urandom_range(3) != 0);
            if ($urandom_range(19) == 0)
                drain();
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_reqs)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_served++;
            end
            else
                rsp_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : rsp_check
        rsp_word_t exp_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result word: status %0d, match_position %0d",
                       rsp_ch.status, rsp_ch.match_position);
                mismatches++;
            end
            else
            begin
                exp_w = awaited_results.pop_front();
                if (rsp_ch.status !== exp_w.st)
                begin
                    $error("status: expected %0d, got %0d", exp_w.st, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.match_position !== exp_w.pos)
                begin
                    $error("match_position: expected %0d, got %0d",
                           exp_w.pos, rsp_ch.match_position);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles < WATCHDOG_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("kmp_stream_matcher_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_start;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = kmp_pkg::REQ_PATTERN;
        req_ch.first_of_run = 1'b0;
        req_ch.data_byte    = '0;
        req_ch.last_of_text = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TABLE[r])
            send_word(DIR_TABLE[r].rq, DIR_TABLE[r].fst, DIR_TABLE[r].c, DIR_TABLE[r].lst,
                      DIR_TABLE[r].typed, DIR_TABLE[r].st, DIR_TABLE[r].pos);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                    // receiver holds off while words keep coming, block backs up
                    hold_reqs <= hold_reqs + 1;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct <= 63;
                end
                default:
                begin
                    send_idle_pct = 37;
                    stall_pct <= 37;
                end
            endcase
            phase_start = sent_words;
            while (sent_words - phase_start < PHASE_WORDS)
                run_sequence((sent_words == phase_start) ? OVF_KIND : int'($urandom_range(99)));
            drain();
        end

        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("kmp_stream_matcher_tb OK");
        else
            $display("kmp_stream_matcher_tb NOT OK");
        $finish;
    end

endmodule
